/* rtl/premultiplied_alpha_downsample_2x2_unit_defines.svh */
// assertion macros for the 2x2 premultiplied alpha downsampler checker
// no dependencies
`ifndef PREMULTIPLIED_ALPHA_DOWNSAMPLE_2X2_UNIT_DEFINES_SVH
`define PREMULTIPLIED_ALPHA_DOWNSAMPLE_2X2_UNIT_DEFINES_SVH

// same-cycle implication
`define PADS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pads assertion failed");

// next-cycle implication
`define PADS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pads assertion failed");

`endif

/* rtl/pads_pkg.sv */
// shared types and constants of the 2x2 premultiplied alpha downsampler
// no dependencies
package pads_pkg;

   localparam int MAX_OUT_WIDTH = 1024;
   localparam int ADDR_W        = $clog2(MAX_OUT_WIDTH);
   localparam int COL_W         = 11;
   localparam int PIX_W         = 8;
   localparam int PROD_W        = 2 * PIX_W;
   localparam int PAIR_W        = PROD_W + 1;
   localparam int PAIR_A_W      = PIX_W + 1;
   localparam int TOTAL_W       = PAIR_W + 1;
   localparam int TOTAL_A_W     = PAIR_A_W + 1;
   localparam int NUM_COLOURS   = 3;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [COL_W-1:0] OUT_WIDTH_RESET = COL_W'(MAX_OUT_WIDTH);

   typedef enum logic [0:0] {
      REG_OUT_WIDTH = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [NUM_COLOURS-1:0][PAIR_W-1:0] c;
      logic [PAIR_A_W-1:0]                a;
   } sums_type;

endpackage

/* rtl/premultiplied_alpha_downsample_2x2_unit.sv */
// top level of the 2x2 premultiplied alpha downsampler; uses pads_pkg
// input: one supersampled rgba pixel per transfer on req_, raster order,
// rows of 2*out_width pixels. output: one rgba pixel per 2x2 block on rsp_.
// out_width is set through the csr_ port; writing it restarts the frame at
// column 0 of an even row. the line store keeps the even row's pair sums.
// a pixel passes through accept and multiply/accumulate unless it closes a
// block; then the line store read, colour divides (one quotient bit per
// cycle) and output load follow before the result shows on rsp_valid.
// req_stall is high while a pixel is in work. a waiting result sits in the
// output register, so further pixels are taken while rsp_stall holds it;
// a second result waits in the last step until the register frees.
// reset (synchronous) clears position and handshake state; line store
// contents are undefined until the even row writes them.
module premultiplied_alpha_downsample_2x2_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pads_pkg::PIX_W-1:0]      req_in_red,
   input  logic [pads_pkg::PIX_W-1:0]      req_in_green,
   input  logic [pads_pkg::PIX_W-1:0]      req_in_blue,
   input  logic [pads_pkg::PIX_W-1:0]      req_in_alpha,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pads_pkg::PIX_W-1:0]      rsp_out_red,
   output logic [pads_pkg::PIX_W-1:0]      rsp_out_green,
   output logic [pads_pkg::PIX_W-1:0]      rsp_out_blue,
   output logic [pads_pkg::PIX_W-1:0]      rsp_out_alpha,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pads_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pads_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pads_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import pads_pkg::*;

   localparam int DIV_STEPS = PIX_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int REM_W     = TOTAL_A_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CALC = 5'b00010,
      S_READ = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [COL_W-1:0]   out_width_ff, out_width_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               odd_row_ff, odd_row_in;
   logic [PIX_W-1:0]   pix_c_ff [NUM_COLOURS];
   logic [PIX_W-1:0]   pix_a_ff;
   sums_type           pair_ff, pair_in;
   sums_type           row_store [MAX_OUT_WIDTH];
   sums_type           store_rd_ff;
   logic [REM_W-1:0]   rem_ff [NUM_COLOURS];
   logic [REM_W-1:0]   rem_in [NUM_COLOURS];
   logic [PIX_W-1:0]   quo_ff [NUM_COLOURS];
   logic [PIX_W-1:0]   quo_in [NUM_COLOURS];
   logic [REM_W-1:0]   divisor_ff;
   logic [PIX_W-1:0]   alpha_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_c_ff [NUM_COLOURS];
   logic [PIX_W-1:0]   rsp_a_ff;

   logic               accept;
   logic               csr_write;
   logic               store_we;
   logic               store_re;
   logic               rsp_load;
   logic [COL_W-1:0]   width_eff;
   logic [COL_W:0]     col_next;
   logic [ADDR_W-1:0]  col_x;
   logic [PROD_W-1:0]  prod [NUM_COLOURS];
   logic [TOTAL_W-1:0] total_c [NUM_COLOURS];
   logic [TOTAL_A_W-1:0] total_a;
   logic [REM_W:0]     trial [NUM_COLOURS];

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (reg_index_type'(csr_paddr[2]) == REG_OUT_WIDTH);
   assign csr_prdata = (reg_index_type'(csr_paddr[2]) == REG_OUT_WIDTH) ?
                       CSR_DATA_W'(out_width_ff) : '0;
   assign out_width_in = csr_pwdata[COL_W-1:0];

   always_comb begin
      priority if (out_width_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (out_width_ff > COL_W'(MAX_OUT_WIDTH)) begin
         width_eff = COL_W'(MAX_OUT_WIDTH);
      end else begin
         width_eff = out_width_ff;
      end
   end

   assign col_x    = col_ff[COL_W-1:1];
   assign store_we = (state_ff == S_CALC) && col_ff[0] && !odd_row_ff;
   assign store_re = (state_ff == S_CALC) && col_ff[0] && odd_row_ff;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // position update at the end of each pixel
   always_comb begin
      col_next   = {1'b0, col_ff} + (COL_W+1)'(1);
      col_in     = col_next[COL_W-1:0];
      odd_row_in = odd_row_ff;
      if (col_next >= {width_eff, 1'b0}) begin
         col_in     = '0;
         odd_row_in = !odd_row_ff;
      end
   end

   // weighted pair sums
   always_comb begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
         prod[i] = pix_c_ff[i] * pix_a_ff;
         if (col_ff[0]) begin
            pair_in.c[i] = pair_ff.c[i] + PAIR_W'(prod[i]);
         end else begin
            pair_in.c[i] = PAIR_W'(prod[i]);
         end
      end
      if (col_ff[0]) begin
         pair_in.a = pair_ff.a + PAIR_A_W'(pix_a_ff);
      end else begin
         pair_in.a = PAIR_A_W'(pix_a_ff);
      end
   end

   // block totals and one restoring divide step per colour
   always_comb begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
         total_c[i] = TOTAL_W'(store_rd_ff.c[i]) + TOTAL_W'(pair_ff.c[i]);
         trial[i]   = {rem_ff[i], quo_ff[i][PIX_W-1]};
         if (trial[i] >= (REM_W+1)'(divisor_ff)) begin
            rem_in[i] = REM_W'(trial[i] - (REM_W+1)'(divisor_ff));
            quo_in[i] = {quo_ff[i][PIX_W-2:0], 1'b1};
         end else begin
            rem_in[i] = REM_W'(trial[i]);
            quo_in[i] = {quo_ff[i][PIX_W-2:0], 1'b0};
         end
      end
      total_a = TOTAL_A_W'(store_rd_ff.a) + TOTAL_A_W'(pair_ff.a);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = store_re ? S_READ : S_IDLE;
         end
         S_READ: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_width_ff <= OUT_WIDTH_RESET;
         col_ff       <= '0;
         odd_row_ff   <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            out_width_ff <= out_width_in;
            col_ff       <= '0;
            odd_row_ff   <= 1'b0;
         end else if (state_ff == S_CALC) begin
            col_ff     <= col_in;
            odd_row_ff <= odd_row_in;
         end
         if (state_ff == S_DIV) begin
            step_ff <= step_ff + STEP_W'(1);
         end else begin
            step_ff <= '0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_c_ff[0] <= req_in_red;
         pix_c_ff[1] <= req_in_green;
         pix_c_ff[2] <= req_in_blue;
         pix_a_ff    <= req_in_alpha;
      end
      if (state_ff == S_CALC) begin
         pair_ff <= pair_in;
      end
      if (state_ff == S_READ) begin
         for (int i = 0; i < NUM_COLOURS; i++) begin
            rem_ff[i] <= total_c[i][TOTAL_W-1:PIX_W];
            quo_ff[i] <= total_c[i][PIX_W-1:0];
         end
         divisor_ff <= total_a;
         alpha_ff   <= total_a[TOTAL_A_W-1:2];
      end else if (state_ff == S_DIV) begin
         for (int i = 0; i < NUM_COLOURS; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
      if (rsp_load) begin
         for (int i = 0; i < NUM_COLOURS; i++) begin
            rsp_c_ff[i] <= (divisor_ff == '0) ? '0 : quo_ff[i];
         end
         rsp_a_ff <= (divisor_ff == '0) ? '0 : alpha_ff;
      end
   end

   // line store of even row pair sums
   always_ff @(posedge clock) begin
      if (store_we) begin
         row_store[col_x] <= pair_in;
      end
      if (store_re) begin
         store_rd_ff <= row_store[col_x];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_c_ff[0];
   assign rsp_out_green = rsp_c_ff[1];
   assign rsp_out_blue  = rsp_c_ff[2];
   assign rsp_out_alpha = rsp_a_ff;

endmodule

/* rtl/pads_checker.sv */
// port-level checker for the 2x2 premultiplied alpha downsampler and its bind
// uses pads_pkg and premultiplied_alpha_downsample_2x2_unit_defines.svh
`include "premultiplied_alpha_downsample_2x2_unit_defines.svh"
module pads_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [pads_pkg::PIX_W-1:0] rsp_out_red,
   input logic [pads_pkg::PIX_W-1:0] rsp_out_green,
   input logic [pads_pkg::PIX_W-1:0] rsp_out_blue,
   input logic [pads_pkg::PIX_W-1:0] rsp_out_alpha
);
   import pads_pkg::*;

   logic [4*PIX_W-1:0] rsp_payload;

   assign rsp_payload = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha};

   // a stalled result stays offered
   `PADS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // and keeps its payload
   `PADS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   // one pixel in work at a time
   `PADS_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall)

   // a new result is only loaded while a pixel is in work
   `PADS_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind premultiplied_alpha_downsample_2x2_unit pads_checker u_pads_checker (.*);

/* dv/premultiplied_alpha_downsample_2x2_unit_tb.sv */
// testbench for the 2x2 premultiplied alpha downsampler: directed blocks, then random
// frames under varied idling, each output checked against an in-bench box filter model
// depends on pads_pkg and premultiplied_alpha_downsample_2x2_unit
module premultiplied_alpha_downsample_2x2_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pads_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 30;
   localparam int unsigned REG_STRIDE    = 4;
   localparam int unsigned RANDOM_PIXELS = 400;
   localparam int unsigned WIDE_PIXELS   = 48;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] alpha;
   } rgba_type;

   typedef struct {
      int unsigned r;
      int unsigned g;
      int unsigned b;
      int unsigned a;
   } weighted_sums_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_in_red   = '0;
   logic [PIX_W-1:0]      req_in_green = '0;
   logic [PIX_W-1:0]      req_in_blue  = '0;
   logic [PIX_W-1:0]      req_in_alpha = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [PIX_W-1:0]      rsp_out_red;
   logic [PIX_W-1:0]      rsp_out_green;
   logic [PIX_W-1:0]      rsp_out_blue;
   logic [PIX_W-1:0]      rsp_out_alpha;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rgba_type          pixels_to_send[$];
   rgba_type          expected_pixels[$];
   int unsigned       send_idle_pct = 0;
   int unsigned       stall_pct     = 0;
   int unsigned       error_count   = 0;
   int unsigned       cycle_count   = 0;

   // model state
   logic [COL_W-1:0]  width_cfg = OUT_WIDTH_RESET;
   int unsigned       column_pos;
   bit                odd_row;
   weighted_sums_type pair_acc;
   weighted_sums_type line_sums[MAX_OUT_WIDTH];

   premultiplied_alpha_downsample_2x2_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .req_in_alpha  (req_in_alpha),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic void restart_frame(input logic [COL_W-1:0] value);
      width_cfg  = value;
      column_pos = 0;
      odd_row    = 1'b0;
      pair_acc   = '{default: 0};
   endfunction

   function automatic void downsample_pixel(input rgba_type px);
      int unsigned       w;
      int unsigned       x;
      int unsigned       alpha;
      weighted_sums_type total;
      rgba_type          result;
      w = width_cfg;
      if (w == 0) w = 1;
      if (w > MAX_OUT_WIDTH) w = MAX_OUT_WIDTH;
      if (column_pos >= 2 * w) column_pos = 0;
      x     = column_pos >> 1;
      alpha = 32'(px.alpha);
      if ((column_pos & 1) == 0) begin
         pair_acc.r = 32'(px.red) * alpha;
         pair_acc.g = 32'(px.green) * alpha;
         pair_acc.b = 32'(px.blue) * alpha;
         pair_acc.a = alpha;
      end else begin
         pair_acc.r += 32'(px.red) * alpha;
         pair_acc.g += 32'(px.green) * alpha;
         pair_acc.b += 32'(px.blue) * alpha;
         pair_acc.a += alpha;
         if (x < MAX_OUT_WIDTH) begin
            if (!odd_row) begin
               line_sums[x] = pair_acc;
            end else begin
               total.r = line_sums[x].r + pair_acc.r;
               total.g = line_sums[x].g + pair_acc.g;
               total.b = line_sums[x].b + pair_acc.b;
               total.a = line_sums[x].a + pair_acc.a;
               if (total.a == 0) begin
                  result = '0;
               end else begin
                  result.red   = PIX_W'(total.r / total.a);
                  result.green = PIX_W'(total.g / total.a);
                  result.blue  = PIX_W'(total.b / total.a);
                  result.alpha = PIX_W'(total.a / 4);
               end
               expected_pixels.push_back(result);
            end
         end
      end
      column_pos++;
      if (column_pos >= 2 * w) begin
         column_pos = 0;
         odd_row    = ~odd_row;
      end
   endfunction

   function automatic void compare_channel(input string name, input logic [PIX_W-1:0] want,
                                           input logic [PIX_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic rgba_type random_pixel(input bit sparse);
      rgba_type    px;
      int unsigned pick;
      px.red   = PIX_W'($urandom_range(255));
      px.green = PIX_W'($urandom_range(255));
      px.blue  = PIX_W'($urandom_range(255));
      pick     = $urandom_range(99);
      if (pick < (sparse ? 80 : 15)) px.alpha = '0;
      else if (pick < (sparse ? 85 : 35)) px.alpha = '1;
      else px.alpha = PIX_W'($urandom_range(255));
      return px;
   endfunction

   task automatic push_pixel(input int r, input int g, input int b, input int a);
      pixels_to_send.push_back(rgba_type'{PIX_W'(r), PIX_W'(g), PIX_W'(b), PIX_W'(a)});
   endtask

   task automatic set_idling(input int unsigned profile);
      case (profile % 4)
         0: begin
            send_idle_pct = 0;  stall_pct = 0;
         end
         1: begin
            send_idle_pct = 52; stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;  stall_pct = 52;
         end
         default: begin
            send_idle_pct = 31; stall_pct = 31;
         end
      endcase
   endtask

   task automatic csr_access(input bit wr, input reg_index_type idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(REG_STRIDE * idx);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_out_width(input logic [COL_W-1:0] want);
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, REG_OUT_WIDTH, '0, readback);
      if (readback !== CSR_DATA_W'(want)) begin
         $display("%0t ns: out_width readback mismatch, expected %0d, got %0d",
                  $time, want, readback);
         error_count++;
      end
   endtask

   task automatic write_out_width(input int unsigned value);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, REG_OUT_WIDTH, CSR_DATA_W'(value), unused);
      restart_frame(COL_W'(value));
      check_out_width(COL_W'(value));
   endtask

   // sender holds off until every transfer is done and the block has gone quiet
   task automatic wait_drained();
      while (pixels_to_send.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : pixel_driver
      rgba_type next_px;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            downsample_pixel(rgba_type'{req_in_red, req_in_green, req_in_blue, req_in_alpha});
         if (!req_valid || !req_stall) begin
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_px       = pixels_to_send.pop_front();
               req_valid    <= 1'b1;
               req_in_red   <= next_px.red;
               req_in_green <= next_px.green;
               req_in_blue  <= next_px.blue;
               req_in_alpha <= next_px.alpha;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : pixel_monitor
      rgba_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t ns: unexpected output transfer, expected none, got %0d %0d %0d %0d",
                     $time, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            compare_channel("red",   want.red,   rsp_out_red);
            compare_channel("green", want.green, rsp_out_green);
            compare_channel("blue",  want.blue,  rsp_out_blue);
            compare_channel("alpha", want.alpha, rsp_out_alpha);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned random_count;
      int unsigned phase;
      int unsigned count;
      random_count = 0;
      phase        = 0;
      restart_frame(OUT_WIDTH_RESET);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_out_width(OUT_WIDTH_RESET);

      // single output column: opaque, transparent, black, lone pixel, small alphas
      set_idling(0);
      write_out_width(1);
      repeat (4) push_pixel(255, 255, 255, 255);
      repeat (4) push_pixel(255, 255, 255, 0);
      repeat (4) push_pixel(0, 0, 0, 255);
      push_pixel(200, 100, 50, 255);
      repeat (3) push_pixel(255, 255, 255, 0);
      push_pixel(10, 200, 255, 1);
      push_pixel(255, 0, 128, 2);
      push_pixel(7, 77, 177, 3);
      push_pixel(128, 64, 32, 4);
      wait_drained();

      // zero width behaves as one
      set_idling(1);
      write_out_width(0);
      push_pixel(255, 0, 255, 128);
      push_pixel(0, 255, 0, 127);
      push_pixel(1, 2, 3, 0);
      push_pixel(254, 253, 252, 255);
      wait_drained();

      // start of an even row at the widest setting
      set_idling(3);
      write_out_width(MAX_OUT_WIDTH);
      repeat (WIDE_PIXELS) pixels_to_send.push_back(random_pixel(1'b0));
      wait_drained();

      // oversized width, start of an even row
      set_idling(2);
      write_out_width((1 << COL_W) - 1);
      repeat (WIDE_PIXELS) pixels_to_send.push_back(random_pixel(1'b0));
      wait_drained();

      // random frames; every third phase carries on mid-frame after a full drain
      while (random_count < RANDOM_PIXELS) begin
         set_idling(phase);
         if (phase % 3 != 2) begin
            if ($urandom_range(9) == 0) write_out_width($urandom_range(40, 9));
            else write_out_width($urandom_range(6, 1));
         end
         count = $urandom_range(80, 20);
         repeat (count) pixels_to_send.push_back(random_pixel(phase % 4 == 1));
         random_count += count;
         wait_drained();
         phase++;
      end

      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
